// ----- design/cse_pkg.sv -----
// Shared types, constants and helper functions of the CAN signal extract and publish block.
`default_nettype none
package cse_pkg;

  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_LAYOUT = 2'd0,
    SEL_SCALE  = 2'd1,
    SEL_OFFSET = 2'd2,
    SEL_LIMITS = 2'd3
  } word_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_CHECK, ST_MUL, ST_SIGN, ST_OFFS, ST_ABS, ST_RMUL,
    ST_DIVA, ST_WAITA, ST_DIVB, ST_WAITB, ST_RFIN, ST_DEAD, ST_INTV, ST_PUB,
    ST_NEXT, ST_FLUSH
  } state_t;

  localparam int LAYOUT_W  = 47;
  localparam int SCALE_W   = 32;
  localparam int OFFSET_W  = 48;
  localparam int LIMITS_W  = 52;
  localparam int POW_W     = 14;
  localparam int DEC_MAX   = 4;
  localparam int RES_MAX   = 16;
  localparam int MS_TO_US  = 1000;
  localparam int RND_HALF  = 32768;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        en;
    word_sel_t   sel;
    logic [63:0] word;
  } def_wr_t;

  typedef struct packed {
    logic        en;
    logic [63:0] value;
    logic [63:0] time_us;
  } hist_wr_t;

  typedef struct packed {
    logic                  valid;
    logic [LAYOUT_W-2:0]   layout;
    logic [SCALE_W-1:0]    scale;
    logic [OFFSET_W-1:0]   offset;
    logic [LIMITS_W-1:0]   limits;
    logic                  has_pub;
    logic [63:0]           last_val;
    logic [63:0]           last_time;
  } entry_rd_t;

  function automatic logic [POW_W-1:0] pow10(input logic [2:0] d);
    logic [POW_W-1:0] p;
    case (d)
      3'd0: p = 14'd1;
      3'd1: p = 14'd10;
      3'd2: p = 14'd100;
      3'd3: p = 14'd1000;
      3'd4: p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag);
    logic [63:0] r;
    if (neg) begin
      r = mag[63] ? S64_MIN : (~mag + 64'd1);
    end else begin
      r = mag[63] ? S64_MAX : mag;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/cse_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, shared by both rounding steps.
`default_nettype none
module cse_div
  import cse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [63:0]       dividend,
  input  wire logic [POW_W-1:0]  divisor,
  output logic                   busy,
  output logic                   done,
  output logic [63:0]            quo,
  output logic [POW_W-1:0]       rem
);

  logic [6:0]     cnt;
  logic [POW_W:0] trial;
  logic           ge;
  logic [POW_W:0] diff;

  assign trial = {rem, quo[63]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  assign busy  = cnt != 7'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 7'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[62:0], ge};
      rem <= ge ? diff[POW_W-1:0] : trial[POW_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- design/cse_store.sv -----
// Signal definition table and publish history memories with their valid flags.
`default_nettype none
module cse_store
  import cse_pkg::*;
#(
  parameter int ENTRIES = 16,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire def_wr_t       def_wr,
  input  wire logic [IW-1:0] def_addr,
  input  wire logic          clear_all,
  input  wire hist_wr_t      hist_wr,
  input  wire logic [IW-1:0] rd_addr,
  output entry_rd_t          rd
);

  logic [LAYOUT_W-2:0] layout_mem [ENTRIES];
  logic [SCALE_W-1:0]  scale_mem  [ENTRIES];
  logic [OFFSET_W-1:0] offset_mem [ENTRIES];
  logic [LIMITS_W-1:0] limits_mem [ENTRIES];
  logic [63:0]         value_mem  [ENTRIES];
  logic [63:0]         time_mem   [ENTRIES];
  logic [ENTRIES-1:0]  lay_valid;
  logic [ENTRIES-1:0]  pub;

  always_ff @(posedge clk) begin
    if (def_wr.en) begin
      case (def_wr.sel)
        SEL_LAYOUT: layout_mem[def_addr] <= def_wr.word[LAYOUT_W-1:1];
        SEL_SCALE:  scale_mem[def_addr]  <= def_wr.word[SCALE_W-1:0];
        SEL_OFFSET: offset_mem[def_addr] <= def_wr.word[OFFSET_W-1:0];
        default:    limits_mem[def_addr] <= def_wr.word[LIMITS_W-1:0];
      endcase
    end
    if (hist_wr.en) begin
      value_mem[rd_addr] <= hist_wr.value;
      time_mem[rd_addr]  <= hist_wr.time_us;
    end
  end

  always_ff @(posedge clk) begin
    rd.layout    <= layout_mem[rd_addr];
    rd.scale     <= scale_mem[rd_addr];
    rd.offset    <= offset_mem[rd_addr];
    rd.limits    <= limits_mem[rd_addr];
    rd.last_val  <= value_mem[rd_addr];
    rd.last_time <= time_mem[rd_addr];
    rd.valid     <= lay_valid[rd_addr];
    rd.has_pub   <= pub[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lay_valid <= '0;
      pub       <= '0;
    end else begin
      if (clear_all) begin
        pub <= '0;
      end
      if (def_wr.en && def_wr.sel == SEL_LAYOUT) begin
        lay_valid[def_addr] <= def_wr.word[0];
        pub[def_addr]       <= 1'b0;
      end
      if (hist_wr.en) begin
        pub[rd_addr] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/can_signal_extract_publish.sv -----
// Top level: frame decoder sequencer, scaling and rounding datapath and output staging.
// A write or clear transaction completes on acceptance. A decode transaction walks the
// table one entry at a time: an entry that does not match goes through ST_READ, ST_CHECK
// and ST_NEXT; a matching entry makes two passes through the shared radix-2 divider used
// for decimal rounding (entries with more than four decimals skip the divider).
// A publish also waits while both the output register and the held result are full.
// Results leave through an output register plus one held result, so the final result
// of a frame can carry tlast; a new transaction is taken once the walk has ended.
`default_nettype none
module can_signal_extract_publish
  import cse_pkg::*;
#(
  parameter int ENTRIES          = 16,
  parameter int FRAME_BYTES      = 8,
  parameter int MAX_SIGNAL_BYTES = 4
)
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // frame_id, frame_len, frame_data, time_us, entry, word_sel, word_value, zero pad
  input  wire logic [231:0] s_tdata,
  // op
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // signal_index, source_id, value_q16, zero pad
  output logic [103:0]      m_tdata,
  output logic              m_tlast
);

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RAW_W = 8 * MAX_SIGNAL_BYTES;

  state_t state, state_next;

  logic [28:0] in_id;
  logic [3:0]  in_len;
  logic [63:0] in_data;
  logic [63:0] in_time;
  logic [3:0]  in_entry;
  op_t         in_op;
  logic        accept;
  logic        ent_ok;

  assign in_id    = s_tdata[28:0];
  assign in_len   = s_tdata[32:29];
  assign in_data  = s_tdata[96:33];
  assign in_time  = s_tdata[160:97];
  assign in_entry = s_tdata[164:161];
  assign in_op    = op_t'(s_tuser);
  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign ent_ok   = 32'(in_entry) < ENTRIES;

  logic [28:0]      fid;
  logic [3:0]       flen;
  logic [63:0]      data;
  logic [63:0]      now;
  logic [IW:0]      idx;
  logic [4:0]       count;
  logic [RAW_W-1:0] raw_q;
  logic [31:0]      smag;
  logic             sneg;
  logic [63:0]      prod;
  logic [63:0]      v;
  logic             neg;
  logic [63:0]      mag;
  logic [63:0]      n;
  logic [63:0]      q;
  logic [POW_W-1:0] r;
  logic [16:0]      frac;

  def_wr_t   def_wr;
  hist_wr_t  hist_wr;
  entry_rd_t rd;

  cse_store #(.ENTRIES(ENTRIES)) u_store (
    .clk       (clk),
    .rst       (rst),
    .def_wr    (def_wr),
    .def_addr  (IW'(in_entry)),
    .clear_all (accept && in_op == OP_CLEAR),
    .hist_wr   (hist_wr),
    .rd_addr   (idx[IW-1:0]),
    .rd        (rd)
  );

  assign def_wr.en   = accept && in_op == OP_WRITE && ent_ok;
  assign def_wr.sel  = word_sel_t'(s_tdata[166:165]);
  assign def_wr.word = s_tdata[230:167];

  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [63:0]      div_arg;
  logic [63:0]      div_quo;
  logic [POW_W-1:0] div_rem;
  logic [POW_W-1:0] p;

  assign p         = pow10(rd.limits[2:0]);
  assign div_start = state == ST_DIVA || state == ST_DIVB;
  assign div_arg   = (state == ST_DIVA) ? n : ({32'd0, 16'(r), 16'd0} + 64'(p >> 1));

  cse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_arg),
    .divisor  (p),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Byte gathering and frame checks for the entry just read.
  logic [2:0]       nb;
  logic [1:0]       nib;
  logic [3:0]       flen_eff;
  logic             bytes_ok;
  logic [RAW_W-1:0] raw_b;
  logic [RAW_W-1:0] raw;
  logic             hit;

  assign nb  = rd.layout[31:29];
  assign nib = rd.layout[33:32];

  always_comb begin
    bytes_ok = 1'b1;
    raw_b    = '0;
    for (int k = 0; k < MAX_SIGNAL_BYTES; k++) begin
      if (3'(k) < nb) begin
        if ({1'b0, rd.layout[34+3*k +: 3]} >= flen) begin
          bytes_ok = 1'b0;
        end
        raw_b[8*k +: 8] = data[8*rd.layout[34+3*k +: 3] +: 8];
      end
    end
    raw = raw_b;
    if (nb == 3'd1) begin
      if (nib == 2'd2) begin
        raw = raw_b >> 4;
      end else if (nib == 2'd1) begin
        raw = raw_b & RAW_W'(NIBBLE_MASK);
      end
    end
  end

  assign flen_eff = (32'(in_len) > FRAME_BYTES) ? 4'(FRAME_BYTES) : in_len;
  assign hit = rd.valid && rd.layout[28:0] == fid && nb != 3'd0 &&
               32'(nb) <= MAX_SIGNAL_BYTES && bytes_ok;

  logic [RAW_W+31:0] mul_full;
  logic [63:0]       off;
  logic [63:0]       sum;
  logic              ovf;
  logic [61:0]       hi_prod;
  logic [30:0]       lo_prod;
  logic [63:0]       back;

  assign mul_full = (RAW_W+32)'(raw_q) * (RAW_W+32)'(smag);
  assign off      = {{(64-OFFSET_W){rd.offset[OFFSET_W-1]}}, rd.offset};
  assign sum      = v + off;
  assign ovf      = v[63] == off[63] && sum[63] != v[63];
  assign hi_prod  = 62'(mag[63:16]) * 62'(p);
  assign lo_prod  = 31'(mag[15:0]) * 31'(p) + 31'(RND_HALF);
  assign back     = (q << 16) + 64'(frac);

  logic [63:0] diff;
  logic        in_band;
  logic [23:0] min_ms;
  logic [33:0] min_us;
  logic        too_soon;

  assign diff     = ($signed(v) >= $signed(rd.last_val)) ? v - rd.last_val : rd.last_val - v;
  assign in_band  = diff <= 64'(rd.limits[51:27]);
  assign min_ms   = rd.limits[26:3];
  assign min_us   = 34'(min_ms) * 34'(MS_TO_US);
  assign too_soon = min_ms != 24'd0 && (now - rd.last_time) < 64'(min_us);

  logic        pend_valid;
  logic [3:0]  pend_idx;
  logic [63:0] pend_val;
  logic        out_free;
  logic        can_move;
  logic        load_out;
  logic        last_ent;

  assign out_free = !m_tvalid || m_tready;
  assign can_move = !pend_valid || out_free;
  assign load_out = (state == ST_PUB && pend_valid && out_free) ||
                    (state == ST_FLUSH && pend_valid && out_free);
  assign last_ent = idx + (IW+1)'(1) == (IW+1)'(ENTRIES);

  assign hist_wr.en      = state == ST_PUB && can_move;
  assign hist_wr.value   = v;
  assign hist_wr.time_us = now;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && in_op == OP_DECODE) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = hit ? ST_MUL : ST_NEXT;
      ST_MUL:   state_next = ST_SIGN;
      ST_SIGN:  state_next = ST_OFFS;
      ST_OFFS:  state_next = ST_ABS;
      ST_ABS:   state_next = (rd.limits[2:0] > 3'(DEC_MAX)) ? ST_DEAD : ST_RMUL;
      ST_RMUL:  state_next = ST_DIVA;
      ST_DIVA:  state_next = ST_WAITA;
      ST_WAITA: if (div_done) state_next = ST_DIVB;
      ST_DIVB:  state_next = ST_WAITB;
      ST_WAITB: if (div_done) state_next = ST_RFIN;
      ST_RFIN:  state_next = ST_DEAD;
      ST_DEAD: begin
        if (!rd.has_pub) state_next = ST_PUB;
        else if (in_band) state_next = ST_NEXT;
        else state_next = ST_INTV;
      end
      ST_INTV:  state_next = too_soon ? ST_NEXT : ST_PUB;
      ST_PUB:   if (can_move) state_next = ST_NEXT;
      ST_NEXT:  state_next = (last_ent || 32'(count) == RES_MAX) ? ST_FLUSH : ST_READ;
      ST_FLUSH: if (!pend_valid || out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        idx   <= '0;
        count <= '0;
      end
      if (state == ST_NEXT) begin
        idx <= idx + (IW+1)'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_PUB && can_move) begin
        pend_valid <= 1'b1;
        count      <= count + 5'd1;
      end else if (state == ST_FLUSH && out_free) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fid  <= in_id;
      flen <= flen_eff;
      data <= in_data;
      now  <= in_time;
    end
    case (state)
      ST_CHECK: begin
        raw_q <= raw;
        sneg  <= rd.scale[31];
        smag  <= rd.scale[31] ? (~rd.scale + 32'd1) : rd.scale;
      end
      ST_MUL:   prod <= 64'(mul_full);
      ST_SIGN:  v <= sneg ? (~prod + 64'd1) : prod;
      ST_OFFS:  v <= ovf ? (v[63] ? S64_MIN : S64_MAX) : sum;
      ST_ABS: begin
        neg <= v[63];
        mag <= v[63] ? (~v + 64'd1) : v;
      end
      ST_RMUL:  n <= 64'(hi_prod) + 64'(lo_prod[30:16]);
      ST_WAITA: if (div_done) begin
        q <= div_quo;
        r <= div_rem;
      end
      ST_WAITB: if (div_done) frac <= div_quo[16:0];
      ST_RFIN:  v <= from_mag(neg, back);
      default: ;
    endcase
    if (state == ST_PUB && can_move) begin
      pend_idx <= 4'(idx);
      pend_val <= v;
    end
    if (load_out) begin
      m_tdata <= {7'd0, pend_val, fid, pend_idx};
      m_tlast <= state == ST_FLUSH;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("held result left over while idle");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= RES_MAX)
    else $error("result count beyond limit");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_pub_count: assert property (@(posedge clk) disable iff (rst)
    hist_wr.en |=> count == $past(count) + 5'd1)
    else $error("publish did not advance the result count");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the CAN signal extract and publish block.
`timescale 1ns / 1ps
module testbench;
  import cse_pkg::*;

  typedef struct {
    op_t         op;
    logic [28:0] fid;
    logic [3:0]  flen;
    logic [63:0] data;
    logic [63:0] tus;
    logic [3:0]  ent;
    word_sel_t   sel;
    logic [63:0] word;
  } frame_item_t;

  typedef struct {
    logic [3:0]  idx;
    logic [28:0] id;
    logic [63:0] val;
    logic        last;
  } pub_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [231:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic m_tlast;

  can_signal_extract_publish DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  logic [46:0] def_layout [16];
  logic [31:0] def_scale [16];
  logic [47:0] def_offset [16];
  logic [51:0] def_limits [16];
  logic        hist_valid [16];
  logic [63:0] hist_value [16];
  logic [63:0] hist_time [16];

  frame_item_t pending [$];
  pub_t        expected_pubs [$];
  int          next_item = 0;
  int          errors = 0;
  logic [28:0] ids [4];
  logic [63:0] now_us = 64'd0;

  task automatic queue_item(frame_item_t it);
    pending.insert(pending.size(), it);
  endtask

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic [63:0] round_q16(logic [63:0] v, logic [2:0] d);
    logic [63:0] m, p, n, q, back;
    logic neg;
    if (d > 3'd4) return v;
    case (d)
      3'd0: p = 64'd1;
      3'd1: p = 64'd10;
      3'd2: p = 64'd100;
      3'd3: p = 64'd1000;
      default: p = 64'd10000;
    endcase
    neg = v[63];
    m = neg ? -v : v;
    n = (m >> 16) * p + ((((m & 64'hFFFF) * p) + 64'd32768) >> 16);
    q = n / p;
    back = (q << 16) + (((n % p) * 64'd65536 + p / 2) / p);
    if (neg) return back[63] ? S64_MIN : -back;
    return back[63] ? S64_MAX : back;
  endfunction

  task automatic predict_publish(frame_item_t it);
    int count;
    int flen;
    logic [46:0] lay;
    logic [2:0] nb, bi;
    logic [1:0] nib;
    logic [63:0] raw, smag, v, offs, mag;
    logic [51:0] lim;
    logic [23:0] min_ms;
    logic ok;
    pub_t p;
    count = 0;
    case (it.op)
      OP_WRITE: begin
        case (it.sel)
          SEL_LAYOUT: begin
            def_layout[it.ent] = it.word[46:0];
            hist_valid[it.ent] = 1'b0;
            hist_value[it.ent] = '0;
            hist_time[it.ent] = '0;
          end
          SEL_SCALE: def_scale[it.ent] = it.word[31:0];
          SEL_OFFSET: def_offset[it.ent] = it.word[47:0];
          default: def_limits[it.ent] = it.word[51:0];
        endcase
      end
      OP_CLEAR: begin
        for (int i = 0; i < 16; i++) begin
          hist_valid[i] = 1'b0;
          hist_value[i] = '0;
          hist_time[i] = '0;
        end
      end
      OP_DECODE: begin
        flen = (it.flen > 8) ? 8 : it.flen;
        for (int i = 0; i < 16 && count < RES_MAX; i++) begin
          lay = def_layout[i];
          if (!lay[0] || lay[29:1] != it.fid) continue;
          nb = lay[32:30];
          nib = lay[34:33];
          if (nb == 0 || nb > 4) continue;
          ok = 1'b1;
          raw = '0;
          for (int k = 0; k < nb; k++) begin
            bi = lay[35 + 3 * k +: 3];
            if (bi >= flen) begin
              ok = 1'b0;
              break;
            end
            raw |= ((it.data >> (8 * bi)) & 64'hFF) << (8 * k);
          end
          if (!ok) continue;
          if (nb == 1) begin
            if (nib == 2) raw = raw >> 4;
            else if (nib == 1) raw = raw & 64'h0F;
          end
          smag = {32'd0, def_scale[i]};
          if (smag[31]) smag = 64'h1_0000_0000 - smag;
          mag = raw * smag;
          if (def_scale[i][31]) v = mag[63] ? S64_MIN : -mag;
          else v = mag[63] ? S64_MAX : mag;
          offs = {{16{def_offset[i][47]}}, def_offset[i]};
          v = sat_sum(v, offs);
          lim = def_limits[i];
          min_ms = lim[26:3];
          v = round_q16(v, lim[2:0]);
          if (hist_valid[i]) begin
            mag = ($signed(v) >= $signed(hist_value[i])) ? v - hist_value[i]
                                                          : hist_value[i] - v;
            if (mag <= {39'd0, lim[51:27]}) continue;
            if (min_ms != 0 && (it.tus - hist_time[i]) < {40'd0, min_ms} * 64'd1000)
              continue;
          end
          hist_valid[i] = 1'b1;
          hist_value[i] = v;
          hist_time[i] = it.tus;
          p.idx = i[3:0];
          p.id = it.fid;
          p.val = v;
          p.last = 1'b0;
          expected_pubs.insert(expected_pubs.size(), p);
          count++;
        end
        if (count > 0) expected_pubs[expected_pubs.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic frame_item_t wr(int e, word_sel_t s, logic [63:0] w);
    frame_item_t it;
    it = '{OP_WRITE, 29'(r64()), 4'(r64()), r64(), r64(), e[3:0], s, w};
    return it;
  endfunction

  function automatic frame_item_t frm(logic [28:0] id, logic [3:0] len, logic [63:0] d,
                                     logic [63:0] t);
    frame_item_t it;
    it = '{OP_DECODE, id, len, d, t, 4'($urandom), word_sel_t'($urandom_range(0, 3)), r64()};
    return it;
  endfunction

  function automatic logic [63:0] rnd_layout();
    logic [2:0] nb;
    nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    return {17'd0, 12'($urandom), 2'($urandom), nb, ids[$urandom_range(0, 3)],
            1'($urandom_range(0, 5) != 0)};
  endfunction

  function automatic logic [63:0] rnd_limits();
    logic [24:0] dead;
    logic [23:0] ms;
    dead = ($urandom_range(0, 4) == 0) ? 25'($urandom) : 25'($urandom_range(0, 3) << 14);
    ms = ($urandom_range(0, 2) == 0) ? 24'($urandom_range(1, 4)) : 24'd0;
    if ($urandom_range(0, 20) == 0) ms = 24'hFFFFFF;
    return {r64()} & ~64'h000F_FFFF_FFFF_FFFF | {12'd0, dead, ms, 3'($urandom)};
  endfunction

  task automatic add_frame();
    frame_item_t it;
    now_us += $urandom_range(0, 3000);
    it = frm(ids[$urandom_range(0, 3)], ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd8,
             r64(), now_us);
    if ($urandom_range(0, 15) == 0) it.fid = 29'($urandom);
    if ($urandom_range(0, 20) == 0) it.tus = r64();
    queue_item(it);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int gap_left = 0;
  int burst_left = 4;
  logic took = 1'b0;
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (next_item < pending.size()) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending[next_item].op;
        s_tdata <= {1'b0, pending[next_item].word, pending[next_item].sel,
                    pending[next_item].ent, pending[next_item].tus,
                    pending[next_item].data, pending[next_item].flen,
                    pending[next_item].fid};
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    took = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      predict_publish(pending[next_item]);
      next_item++;
      took = 1'b1;
    end
  end

  // Receiver: changing stall pattern plus one long hold-off.
  int hold_left = 0;
  int mode = 0;
  logic held_once = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      if (!held_once && next_item > 63) begin
        held_once = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 4) == 0);
          default: m_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    pub_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pubs.size() == 0) begin
        $display("%0t: unexpected transaction idx=%0d id=%h val=%h last=%b", $realtime,
                 m_tdata[3:0], m_tdata[32:4], m_tdata[96:33], m_tlast);
        errors++;
      end else begin
        e = expected_pubs.pop_front();
        if (m_tdata[3:0] !== e.idx || m_tdata[32:4] !== e.id || m_tdata[96:33] !== e.val ||
            m_tlast !== e.last || m_tdata[103:97] !== '0) begin
          $display("%0t: expected idx=%0d id=%h val=%h last=%b, got idx=%0d id=%h val=%h last=%b",
                   $realtime, e.idx, e.id, e.val, e.last, m_tdata[3:0], m_tdata[32:4],
                   m_tdata[96:33], m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    frame_item_t it;
    ids[0] = 29'd0;
    ids[1] = 29'h1FFF_FFFF;
    ids[2] = 29'($urandom);
    ids[3] = 29'($urandom);
    for (int i = 0; i < 16; i++) begin
      def_layout[i] = '0;
      hist_valid[i] = 1'b0;
      hist_value[i] = '0;
      hist_time[i] = '0;
    end
    // Every entry gets scale, offset and limits before any layout marks it valid.
    for (int i = 0; i < 16; i++) begin
      queue_item(wr(i, SEL_SCALE, r64()));
      queue_item(wr(i, SEL_OFFSET, r64()));
      queue_item(wr(i, SEL_LIMITS, rnd_limits()));
    end
    // Directed: extreme scales and offsets, nibble selection, both ends of the decimal range.
    queue_item(wr(0, SEL_SCALE, 64'h7FFF_FFFF));
    queue_item(wr(0, SEL_OFFSET, 64'h7FFF_FFFF_FFFF));
    queue_item(wr(0, SEL_LIMITS, 64'd4));
    queue_item(wr(0, SEL_LAYOUT, {17'd0, 12'o7654, 2'd0, 3'd4, ids[1], 1'b1}));
    queue_item(wr(1, SEL_SCALE, 64'h8000_0000));
    queue_item(wr(1, SEL_OFFSET, 64'h8000_0000_0000));
    queue_item(wr(1, SEL_LIMITS, 64'd0));
    queue_item(wr(1, SEL_LAYOUT, {17'd0, 12'o0123, 2'd0, 3'd4, ids[1], 1'b1}));
    queue_item(wr(2, SEL_LAYOUT, {17'd0, 12'o0007, 2'd2, 3'd1, ids[1], 1'b1}));
    queue_item(wr(3, SEL_LAYOUT, {17'd0, 12'o0000, 2'd1, 3'd1, ids[1], 1'b1}));
    queue_item(wr(4, SEL_LAYOUT, {17'd0, 12'o0012, 2'd2, 3'd2, ids[1], 1'b1}));
    queue_item(wr(5, SEL_LAYOUT, {17'd0, 12'o0000, 2'd0, 3'd0, ids[1], 1'b1}));
    queue_item(wr(6, SEL_LAYOUT, {17'd0, 12'o0000, 2'd0, 3'd5, ids[1], 1'b1}));
    queue_item(wr(7, SEL_LAYOUT, {17'd0, 12'o0000, 2'd3, 3'd1, ids[0], 1'b1}));
    queue_item(wr(8, SEL_LAYOUT, {17'd0, 12'o0000, 2'd0, 3'd1, ids[0], 1'b0}));
    queue_item(frm(ids[1], 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0));
    queue_item(frm(ids[1], 4'd15, 64'h0123_4567_89AB_CDEF, 64'd10));
    queue_item(frm(ids[1], 4'd3, 64'h0, 64'd20));
    queue_item(frm(ids[0], 4'd0, 64'hA5, 64'd30));
    queue_item(frm(ids[0], 4'd1, 64'h5A, 64'hFFFF_FFFF_FFFF_FFFF));
    it = frm(ids[1], 4'd8, 64'h1, 64'd40);
    it.op = OP_NONE;
    queue_item(it);
    it.op = OP_CLEAR;
    queue_item(it);
    queue_item(frm(ids[1], 4'd8, 64'h8080_8080_8080_8080, 64'd50));
    // All entries active on one id so a frame publishes sixteen results.
    for (int i = 0; i < 16; i++)
      queue_item(wr(i, SEL_LAYOUT, {17'd0, 12'($urandom_range(0, 4095) & 12'o3333),
                                    2'($urandom), 3'($urandom_range(1, 4)), ids[2],
                                    1'b1}));
    queue_item(frm(ids[2], 4'd8, r64(), 64'd100));
    for (int i = 0; i < 16; i++) queue_item(wr(i, SEL_LAYOUT, rnd_layout()));
    // Random: mostly frames on configured ids, occasional table rewrites and clears.
    for (int n = 0; n < 20; n++) begin
      case ($urandom_range(0, 19))
        0, 1: queue_item(wr($urandom_range(0, 15), SEL_LAYOUT, rnd_layout()));
        2: queue_item(wr($urandom_range(0, 15), SEL_SCALE, r64()));
        3: queue_item(wr($urandom_range(0, 15), SEL_OFFSET, r64()));
        4: queue_item(wr($urandom_range(0, 15), SEL_LIMITS, rnd_limits()));
        5: begin
          it = frm(ids[0], 4'($urandom), r64(), r64());
          it.op = ($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_NONE;
          queue_item(it);
        end
        default: add_frame();
      endcase
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (next_item == pending.size());
    wait (expected_pubs.size() == 0);
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_pubs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
